[hw/rtl/euv_pkg.sv]
// shared types, constants and saturation helper for the encoder unwrap velocity unit
package euv_pkg;

  // field widths
  localparam int unsigned RawW   = 16;
  localparam int unsigned TsW    = 32;
  localparam int unsigned HomeW  = 16;
  localparam int unsigned CprW   = 17;
  localparam int unsigned TickW  = 30;
  localparam int unsigned PosW   = 32;
  localparam int unsigned DegW   = 44;
  localparam int unsigned RadW   = 38;
  localparam int unsigned VelW   = 48;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 168;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // divider sizes
  localparam int unsigned NumW = 78;
  localparam int unsigned DenW = 61;
  localparam int unsigned QW   = 48;
  localparam int unsigned CntW = 7;

  // numerator lengths per operation
  localparam logic [CntW-1:0] DegBits = 7'd57;
  localparam logic [CntW-1:0] RadBits = 7'd63;
  localparam logic [CntW-1:0] VelBits = 7'd78;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_HOME_OFFSET    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COUNTS_PER_REV = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TICK_RATE_HZ   = 2'd2;

  // register reset values
  localparam logic [HomeW-1:0] HOME_RESET = 16'd30000;
  localparam logic [CprW-1:0]  CPR_RESET  = 17'd8192;
  localparam logic [TickW-1:0] TICK_RESET = 30'd1000000;

  // fixed point constants: 2*pi in Q28 and 360 in Q16
  localparam logic [31:0] TWO_PI_Q28 = 32'd1686629713;
  localparam logic [31:0] DEG_Q16    = 32'd23592960;

  // wrap counter limits
  localparam logic signed [15:0] WRAP_MAX = 16'sd32767;
  localparam logic signed [15:0] WRAP_MIN = -16'sd32767;

  // operation selector for the shared multiply / divide sequence
  typedef enum logic [1:0] {
    OP_DEG = 2'd0,
    OP_RAD = 2'd1,
    OP_VEL = 2'd2
  } op_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNWRAP,
    ST_CONT,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_MUL_D,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_ROUND,
    ST_DONE
  } state_t;

  // sign + magnitude to a saturated two's complement field of width w
  function automatic logic [QW-1:0] sat_field(input logic neg, input logic ovf,
                                              input logic [QW:0] mag,
                                              input int unsigned w);
    logic [QW:0] lim;
    logic [QW:0] m;
    lim = (QW+1)'(1) << (w - 1);
    if (neg) begin
      if (ovf || (mag > lim)) begin
        m = lim;
      end else begin
        m = mag;
      end
      m = (QW+1)'(0) - m;
    end else begin
      if (ovf || (mag >= lim)) begin
        m = lim - (QW+1)'(1);
      end else begin
        m = mag;
      end
    end
    return m[QW-1:0];
  endfunction

endpackage

[hw/rtl/encoder_unwrap_velocity_unit.sv]
// multi-turn encoder unwrap with angle and velocity over a shared multiplier and divider
// Sequence: unwrap and continuous-position setup states, then deg/rad/velocity ops, each a
//   multiply, a 57/63/78-step divide and a round; velocity skips its divide when no time has elapsed
// Flow: one item at a time; in_tready is high only while the sequencer is idle,
//   and a result not yet taken holds the next item in the last state until the output frees
// Reset: synchronous active-low rst_n clears state, wraps, last count and timestamp and loads
//   the register defaults; result payload registers are not reset
module encoder_unwrap_velocity_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // input item
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [euv_pkg::InDataW-1:0]     in_tdata,   // raw_count[15:0], timestamp[47:16]
  // result item
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [euv_pkg::OutDataW-1:0]    out_tdata,  // position_counts[31:0],
                                                      // angle_deg_q16[75:32],
                                                      // angle_rad_q16[113:76],
                                                      // velocity_rad_q16[161:114], zeros
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [euv_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [euv_pkg::CfgDataW-1:0]    cfg_data
);
  import euv_pkg::*;

  // control
  state_t state_r, state_nxt;
  op_t    op_r;

  // configuration
  logic [HomeW-1:0] home_r;
  logic [CprW-1:0]  cpr_r;
  logic [TickW-1:0] tick_r;
  logic [CprW-1:0]  cpr_eff;

  // tracking state
  logic signed [17:0] last_r;
  logic signed [15:0] wraps_r;
  logic [TsW-1:0]     last_ts_r;

  // captured item and derived values
  logic [RawW-1:0]    raw_r;
  logic [TsW-1:0]     ts_r;
  logic signed [17:0] cur_r;
  logic signed [17:0] dcorr_r;
  logic [TsW-1:0]     dt_r;
  logic               neg_r;
  logic [31:0]        mag_r;
  logic               vneg_r;
  logic [16:0]        dmag_r;

  // shared multiplier
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  logic [63:0] p_r;
  logic [14:0] nh_r;

  // shared divider
  logic [NumW-1:0] num_r;
  logic [DenW-1:0] den_r;
  logic [DenW-1:0] rem_r;
  logic [QW-1:0]   q_r;
  logic            ovf_r;
  logic [CntW-1:0] cnt_r;
  logic [DenW:0]   div_sh;
  logic            div_ge;
  logic            rnd;
  logic [QW:0]     q_fin;
  logic            op_neg;
  logic [QW-1:0]   sat_q;

  // results and output register
  logic [PosW-1:0] pos_res_r;
  logic [DegW-1:0] deg_res_r;
  logic [RadW-1:0] rad_res_r;
  logic [VelW-1:0] vel_res_r;
  logic            out_valid_r;
  logic [OutDataW-1:0] out_data_r;

  // unwrap arithmetic
  logic signed [17:0] cur;
  logic signed [18:0] delta;
  logic               jump_up, jump_dn;
  logic signed [18:0] dcorr;
  logic signed [33:0] cont;

  assign cpr_eff = (cpr_r == '0) ? CprW'(1) : cpr_r;

  assign cur   = $signed({2'b00, home_r}) - $signed({{2{raw_r[RawW-1]}}, raw_r});
  assign delta = $signed({cur[17], cur}) - $signed({last_r[17], last_r});
  assign jump_up = delta > 19'sd32767;
  assign jump_dn = delta < -19'sd32768;
  always_comb begin
    if (jump_up) begin
      dcorr = delta - 19'sd65536;
    end else if (jump_dn) begin
      dcorr = delta + 19'sd65536;
    end else begin
      dcorr = delta;
    end
  end
  assign cont = $signed({{16{cur_r[17]}}, cur_r}) +
                $signed({{2{wraps_r[15]}}, wraps_r, 16'h0000});

  // divider step and rounding
  assign div_sh = {rem_r, num_r[NumW-1]};
  assign div_ge = div_sh >= {1'b0, den_r};
  assign rnd    = {rem_r, 1'b0} >= {1'b0, den_r};
  assign q_fin  = {1'b0, q_r} + (QW+1)'(rnd);
  assign op_neg = (op_r == OP_VEL) ? vneg_r : neg_r;
  always_comb begin
    case (op_r)
      OP_DEG:  sat_q = sat_field(op_neg, ovf_r, q_fin, DegW);
      OP_RAD:  sat_q = sat_field(op_neg, ovf_r, q_fin, RadW);
      OP_VEL:  sat_q = sat_field(op_neg, ovf_r, q_fin, VelW);
      default: sat_q = '0;
    endcase
  end

  // multiplier operand selection
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state_r)
      ST_MUL_A: begin
        case (op_r)
          OP_DEG: begin
            mul_x = mag_r;
            mul_y = DEG_Q16;
          end
          OP_RAD: begin
            mul_x = mag_r;
            mul_y = TWO_PI_Q28;
          end
          OP_VEL: begin
            mul_x = {15'b0, dmag_r};
            mul_y = {2'b0, tick_r};
          end
          default: begin
            mul_x = '0;
            mul_y = '0;
          end
        endcase
      end
      ST_MUL_B: begin
        mul_x = p_r[31:0];
        mul_y = TWO_PI_Q28;
      end
      ST_MUL_C: begin
        mul_x = {17'b0, nh_r};
        mul_y = TWO_PI_Q28;
      end
      ST_MUL_D: begin
        mul_x = dt_r;
        mul_y = {15'b0, cpr_eff};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_tvalid) state_nxt = ST_UNWRAP;
      ST_UNWRAP:    state_nxt = ST_CONT;
      ST_CONT:      state_nxt = ST_MUL_A;
      ST_MUL_A:     state_nxt = (op_r == OP_VEL) ? ST_MUL_B : ST_DIV_LOAD;
      ST_MUL_B:     state_nxt = ST_MUL_C;
      ST_MUL_C:     state_nxt = ST_MUL_D;
      ST_MUL_D:     state_nxt = ST_DIV_LOAD;
      ST_DIV_LOAD: begin
        if ((op_r == OP_VEL) && (p_r == '0)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN:   if (cnt_r == CntW'(1)) state_nxt = ST_DIV_ROUND;
      ST_DIV_ROUND: state_nxt = (op_r == OP_VEL) ? ST_DONE : ST_MUL_A;
      ST_DONE:      if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    cfg_ready  = 1'b1;
    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_DEG;
      out_valid_r <= 1'b0;
      home_r      <= HOME_RESET;
      cpr_r       <= CPR_RESET;
      tick_r      <= TICK_RESET;
      last_r      <= '0;
      wraps_r     <= '0;
      last_ts_r   <= '0;
    end else begin
      state_r <= state_nxt;
      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_HOME_OFFSET:    home_r <= cfg_data[HomeW-1:0];
          CFG_COUNTS_PER_REV: cpr_r  <= cfg_data[CprW-1:0];
          CFG_TICK_RATE_HZ:   tick_r <= cfg_data[TickW-1:0];
          default: ;
        endcase
      end
      // unwrap and wrap counter update
      if (state_r == ST_UNWRAP) begin
        last_r    <= cur;
        last_ts_r <= ts_r;
        if (jump_up && (wraps_r != WRAP_MIN)) begin
          wraps_r <= wraps_r - 16'sd1;
        end else if (jump_dn && (wraps_r != WRAP_MAX)) begin
          wraps_r <= wraps_r + 16'sd1;
        end
      end
      // operation sequencing
      if (state_r == ST_CONT) begin
        op_r <= OP_DEG;
      end else if ((state_r == ST_DIV_ROUND) && (op_r != OP_VEL)) begin
        op_r <= (op_r == OP_DEG) ? OP_RAD : OP_VEL;
      end
      // output register
      if ((state_r == ST_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        raw_r <= in_tdata[15:0];
        ts_r  <= in_tdata[47:16];
      end
      ST_UNWRAP: begin
        cur_r   <= cur;
        dcorr_r <= dcorr[17:0];
        dt_r    <= ts_r - last_ts_r;
      end
      ST_CONT: begin
        neg_r  <= cont[33];
        mag_r  <= cont[33] ? 32'(-cont) : cont[31:0];
        vneg_r <= dcorr_r[17];
        dmag_r <= dcorr_r[17] ? 17'(-dcorr_r) : dcorr_r[16:0];
        pos_res_r <= PosW'(sat_field(cont[33], 1'b0,
                                     {17'b0, (cont[33] ? 32'(-cont) : cont[31:0])},
                                     PosW));
      end
      ST_MUL_A: begin
        p_r <= mul_p;
      end
      ST_MUL_B: begin
        nh_r <= p_r[46:32];
        p_r  <= mul_p;
      end
      ST_MUL_C: begin
        num_r <= {15'b0, p_r[62:0]};
        p_r   <= mul_p;
      end
      ST_MUL_D: begin
        num_r <= num_r + {p_r[45:0], 32'b0};
        p_r   <= mul_p;
      end
      ST_DIV_LOAD: begin
        rem_r <= '0;
        q_r   <= '0;
        ovf_r <= 1'b0;
        case (op_r)
          OP_DEG: begin
            num_r <= {p_r[56:0], 21'b0};
            den_r <= {44'b0, cpr_eff};
            cnt_r <= DegBits;
          end
          OP_RAD: begin
            num_r <= {p_r[62:0], 15'b0};
            den_r <= {32'b0, cpr_eff, 12'b0};
            cnt_r <= RadBits;
          end
          default: begin
            den_r <= {p_r[48:0], 12'b0};
            cnt_r <= VelBits;
          end
        endcase
        // no elapsed time: velocity reads zero
        if ((op_r == OP_VEL) && (p_r == '0)) begin
          vel_res_r <= '0;
        end
      end
      ST_DIV_RUN: begin
        rem_r <= div_ge ? DenW'(div_sh - {1'b0, den_r}) : div_sh[DenW-1:0];
        num_r <= {num_r[NumW-2:0], 1'b0};
        q_r   <= {q_r[QW-2:0], div_ge};
        ovf_r <= ovf_r | q_r[QW-1];
        cnt_r <= cnt_r - CntW'(1);
      end
      ST_DIV_ROUND: begin
        case (op_r)
          OP_DEG:  deg_res_r <= sat_q[DegW-1:0];
          OP_RAD:  rad_res_r <= sat_q[RadW-1:0];
          default: vel_res_r <= sat_q[VelW-1:0];
        endcase
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= {6'b0, vel_res_r, rad_res_r, deg_res_r, pos_res_r};
        end
      end
      default: ;
    endcase
  end

  // wrap counter never reaches the most negative code
  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    wraps_r != -16'sd32768)
    else $error("wrap counter out of range");

  // partial remainder stays below the divisor while dividing
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_RUN || state_r == ST_DIV_ROUND) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  // an accepted item always starts the unwrap step
  a_accept_unwrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_UNWRAP))
    else $error("accepted item did not start unwrap");

  // a new result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_data_r)))
    else $error("pending result overwritten");

endmodule

[bench/encoder_unwrap_velocity_unit_tb.sv]
// testbench for the encoder unwrap velocity unit: directed and random motion streams checked against a predictor
`timescale 1ns / 1ps

module encoder_unwrap_velocity_unit_tb;
  import euv_pkg::*;

  // result field positions inside out_tdata
  localparam int POS_LSB = 0;
  localparam int DEG_LSB = POS_LSB + PosW;
  localparam int RAD_LSB = DEG_LSB + DegW;
  localparam int VEL_LSB = RAD_LSB + RadW;
  localparam int PAD_LSB = VEL_LSB + VelW;

  // fixed point scales: 360 in Q16, 2*pi in Q28
  localparam logic [63:0] REV_DEG_Q16 = 64'd23592960;
  localparam logic [63:0] REV_RAD_Q28 = 64'd1686629713;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 400;
  localparam int PHASE_ITEMS = 230;

  typedef struct packed {
    logic [TsW-1:0]  stamp;
    logic [RawW-1:0] count;
  } sample_t;

  typedef enum logic [1:0] {
    GAPS_SEND_LIGHT,
    GAPS_SEND_HEAVY,
    GAPS_NONE
  } pacing_t;

  typedef enum logic [1:0] {
    RUN_CREEP,
    RUN_SPIN,
    RUN_HOLD,
    RUN_NOISE
  } motion_kind_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // predictor copy of registers and unwrap state
  logic [HomeW-1:0] home_reg = HOME_RESET;
  logic [CprW-1:0]  cpr_reg = CPR_RESET;
  logic [TickW-1:0] tick_reg = TICK_RESET;
  int               last_cur = 0;
  int               wrap_count = 0;
  logic [TsW-1:0]   last_stamp = '0;

  sample_t             sample_q[$];
  logic [OutDataW-1:0] expected_motion[$];
  int                  n_queued = 0;
  int                  n_taken = 0;
  int                  err_count = 0;
  int                  quiet_cycles = 0;
  logic                in_took = 1'b0;
  pacing_t             pacing = GAPS_SEND_LIGHT;

  // motion generator state
  logic [RawW-1:0] enc_pos = '0;
  logic [TsW-1:0]  stamp = '0;
  int              run_left = 0;
  int              run_step = 0;
  bit              run_fast = 1'b0;
  motion_kind_t    run_kind = RUN_HOLD;

  encoder_unwrap_velocity_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // raw_count[15:0], timestamp[47:16]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // position_counts, angle_deg_q16, angle_rad_q16,
                              // velocity_rad_q16, zeros
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // round(a*b/den) with ties away from zero, all ones when it does not fit 64 bits
  function automatic logic [63:0] scaled_quotient(input logic [63:0] a, input logic [63:0] b,
                                                  input logic [63:0] den);
    logic [127:0] prod;
    logic [127:0] dvs;
    logic [127:0] quo;
    logic [127:0] rem;
    prod = {64'd0, a} * {64'd0, b};
    dvs = {64'd0, den};
    quo = prod / dvs;
    rem = prod % dvs;
    if (rem >= dvs - rem) begin
      quo = quo + 128'd1;
    end
    if (quo[127:64] != 64'd0) begin
      return '1;
    end
    return quo[63:0];
  endfunction

  // sign and magnitude to a saturated two's complement field
  function automatic logic [63:0] clamp_field(input bit neg, input logic [63:0] mag,
                                              input int unsigned w);
    logic [63:0] lim;
    logic [63:0] mask;
    logic [63:0] m;
    lim = 64'd1 << (w - 1);
    mask = (lim << 1) - 64'd1;
    m = mag;
    if (neg) begin
      if (m > lim) begin
        m = lim;
      end
      return (64'd0 - m) & mask;
    end
    if (m > lim - 64'd1) begin
      m = lim - 64'd1;
    end
    return m & mask;
  endfunction

  // unwrap one sample, advance the predictor state and build the expected result word
  function automatic logic [OutDataW-1:0] predict_motion(input logic [RawW-1:0] raw,
                                                         input logic [TsW-1:0] ts);
    int                  cur;
    int                  delta;
    longint              cont;
    bit                  neg;
    bit                  vneg;
    logic [63:0]         mag;
    logic [63:0]         dmag;
    logic [63:0]         cpr;
    logic [63:0]         vel;
    logic [TsW-1:0]      dt;
    logic [OutDataW-1:0] word;
    cur = int'(home_reg) - int'($signed(raw));
    delta = cur - last_cur;
    if (delta > 32767) begin
      if (wrap_count > -32767) begin
        wrap_count = wrap_count - 1;
      end
      delta = delta - 65536;
    end else if (delta < -32768) begin
      if (wrap_count < 32767) begin
        wrap_count = wrap_count + 1;
      end
      delta = delta + 65536;
    end
    cont = longint'(cur) + longint'(wrap_count) * 64'sd65536;
    neg = cont < 0;
    mag = neg ? 64'(-cont) : 64'(cont);
    cpr = (cpr_reg == '0) ? 64'd1 : 64'(cpr_reg);
    word = '0;
    word[POS_LSB +: PosW] = PosW'(clamp_field(neg, mag, PosW));
    word[DEG_LSB +: DegW] = DegW'(clamp_field(neg, scaled_quotient(mag, REV_DEG_Q16, cpr), DegW));
    word[RAD_LSB +: RadW] = RadW'(clamp_field(neg, scaled_quotient(mag, REV_RAD_Q28, cpr << 12),
                                              RadW));
    dt = ts - last_stamp;
    if (dt == '0) begin
      vel = 64'd0;
    end else begin
      vneg = delta < 0;
      dmag = vneg ? 64'(-delta) : 64'(delta);
      vel = clamp_field(vneg, scaled_quotient(dmag * 64'(tick_reg), REV_RAD_Q28,
                                              (64'(dt) * cpr) << 12), VelW);
    end
    word[VEL_LSB +: VelW] = VelW'(vel);
    last_cur = cur;
    last_stamp = ts;
    return word;
  endfunction

  task automatic check_field(input string field_name, input logic [63:0] expv,
                             input logic [63:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %h, got %h", field_name, expv, actv);
      err_count++;
    end
  endtask

  // item driver and result ready, both on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_took) begin
        if (sample_q.size() != 0 &&
            !(pacing == GAPS_SEND_LIGHT && $urandom_range(99) < 30) &&
            !(pacing == GAPS_SEND_HEAVY && $urandom_range(99) < 61)) begin
          in_tdata <= sample_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      case (pacing)
        GAPS_SEND_LIGHT: out_tready <= ($urandom_range(99) >= 61);
        GAPS_SEND_HEAVY: out_tready <= ($urandom_range(99) >= 30);
        default:         out_tready <= 1'b1;
      endcase
    end
  end

  // handshake monitor: prediction on accepted items, checks on results
  always @(posedge clk) begin
    logic [OutDataW-1:0] exp_w;
    in_took <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HOME_OFFSET:    home_reg = cfg_data[HomeW-1:0];
          CFG_COUNTS_PER_REV: cpr_reg = cfg_data[CprW-1:0];
          CFG_TICK_RATE_HZ:   tick_reg = cfg_data[TickW-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_motion.push_back(predict_motion(in_tdata[RawW-1:0], in_tdata[RawW +: TsW]));
        n_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_motion.size() == 0) begin
          $error("result with no item pending: %h", out_tdata);
          err_count++;
        end else begin
          exp_w = expected_motion.pop_front();
          check_field("position_counts", 64'(exp_w[POS_LSB +: PosW]),
                      64'(out_tdata[POS_LSB +: PosW]));
          check_field("angle_deg_q16", 64'(exp_w[DEG_LSB +: DegW]),
                      64'(out_tdata[DEG_LSB +: DegW]));
          check_field("angle_rad_q16", 64'(exp_w[RAD_LSB +: RadW]),
                      64'(out_tdata[RAD_LSB +: RadW]));
          check_field("velocity_rad_q16", 64'(exp_w[VEL_LSB +: VelW]),
                      64'(out_tdata[VEL_LSB +: VelW]));
          check_field("tdata padding", 64'(exp_w[OutDataW-1:PAD_LSB]),
                      64'(out_tdata[OutDataW-1:PAD_LSB]));
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog on cycles without any accepted handshake
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
    end
    $display("encoder_unwrap_velocity_unit_tb: errors");
    $finish;
  end

  task automatic queue_sample(input logic [RawW-1:0] count, input logic [TsW-1:0] ts);
    sample_t smp;
    smp.count = count;
    smp.stamp = ts;
    sample_q.push_back(smp);
    n_queued++;
  endtask

  // runs of creeping, spinning, held and noisy encoder motion
  task automatic queue_motion(input int count);
    int jitter;
    for (int k = 0; k < count; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(60, 4);
        case ($urandom_range(9))
          0, 1, 2, 3: run_kind = RUN_CREEP;
          4, 5, 6:    run_kind = RUN_SPIN;
          7:          run_kind = RUN_HOLD;
          default:    run_kind = RUN_NOISE;
        endcase
        case (run_kind)
          RUN_CREEP: run_step = $urandom_range(300);
          RUN_SPIN:  run_step = $urandom_range(32000, 5000);
          default:   run_step = 0;
        endcase
        if ($urandom_range(1) == 1) begin
          run_step = -run_step;
        end
        run_fast = ($urandom_range(3) == 0);
      end
      run_left--;
      if (run_kind == RUN_NOISE) begin
        enc_pos = RawW'($urandom);
        if ($urandom_range(2) != 0) begin
          stamp = $urandom;
        end
      end else begin
        jitter = int'($urandom_range(6)) - 3;
        enc_pos = enc_pos + RawW'(run_step + jitter);
        // an occasional repeated timestamp
        if ($urandom_range(24) != 0) begin
          stamp = stamp + (run_fast ? $urandom_range(4, 1) : $urandom_range(200000, 1));
        end
      end
      queue_sample(enc_pos, stamp);
    end
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || expected_motion.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!(cfg_valid && cfg_ready));
  endtask

  // reprogram while idle, then stream a block of motion and let it drain
  task automatic run_phase(input logic [HomeW-1:0] home, input logic [CprW-1:0] cpr,
                           input logic [TickW-1:0] tick, input pacing_t pace);
    write_reg(CFG_HOME_OFFSET, CfgDataW'(home));
    write_reg(CFG_COUNTS_PER_REV, CfgDataW'(cpr));
    write_reg(CFG_TICK_RATE_HZ, CfgDataW'(tick));
    @(negedge clk);
    cfg_valid <= 1'b0;
    pacing = pace;
    queue_motion(PHASE_ITEMS);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed items on reset defaults
    queue_sample(16'h8000, 32'h0000_0000);  // first sample wraps against zero, no elapsed time
    queue_sample(16'h7fff, 32'h0000_0064);  // wrap back the other way
    queue_sample(16'h7fff, 32'h0000_0064);  // repeated timestamp
    queue_sample(16'hffff, 32'h0000_0065);
    queue_sample(16'h0000, 32'hffff_ffff);
    queue_sample(16'h0001, 32'h0000_0004);  // timestamp rolls over
    queue_sample(16'h8000, 32'h0000_0005);
    queue_sample(16'h7fff, 32'h0000_0006);
    queue_sample(16'h8001, 32'h0000_0007);
    queue_sample(16'h0000, 32'h0000_0007);
    queue_sample(16'hffff, 32'h8000_0000);
    queue_sample(16'h5555, 32'haaaa_aaaa);
    queue_sample(16'haaaa, 32'h5555_5555);
    queue_sample(16'h7530, 32'h5555_5556);  // raw equal to home
    queue_sample(16'h7531, 32'h5555_5557);
    // jumps right at and just past the wrap thresholds
    queue_sample(16'hf532, 32'h6000_0000);
    queue_sample(16'h7532, 32'h6000_0001);
    queue_sample(16'hf532, 32'h6000_0002);
    queue_sample(16'h7533, 32'h6000_0003);
    wait_drained();

    run_phase(16'd0, 17'd1, 30'h3fff_ffff, GAPS_SEND_LIGHT);
    run_phase(16'hffff, 17'h1ffff, 30'd1, GAPS_SEND_LIGHT);
    // zero counts per rev and zero tick rate
    run_phase(HomeW'($urandom), 17'd0, 30'd0, GAPS_SEND_HEAVY);
    run_phase(HomeW'($urandom), 17'd65536, 30'd1000000000, GAPS_SEND_HEAVY);
    run_phase(HomeW'($urandom), CprW'($urandom), TickW'($urandom), GAPS_NONE);
    run_phase(HOME_RESET, CPR_RESET, TICK_RESET, GAPS_NONE);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("encoder_unwrap_velocity_unit_tb: clean");
    end else begin
      $display("encoder_unwrap_velocity_unit_tb: errors");
    end
    $finish;
  end

endmodule
